// ----- design/ghal_pkg.sv -----
// Shared types and codes for the generational handle allocator.
package ghal_pkg;

    typedef enum logic [1:0] {
        CMD_CREATE  = 2'd0,
        CMD_DESTROY = 2'd1,
        CMD_CHECK   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_STALE = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } alloc_state_t;

endpackage

// ----- design/ghal_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
module ghal_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/generational_handle_allocator_core.sv -----
// Generational handle allocator: an accepted item passes from the IDLE state through EXEC to the result register.
// On accept in IDLE the addressed slot is read from the slot RAM; in EXEC the item checks it,
// writes the slot back and loads the result register.
// Input stall stays high while an item is at work or a result waits with output stall high.
// Reset clears the slot count, sets the free list empty and drops the result valid.
// The slot RAM is not cleared; a slot's contents only count once the slot has been handed out.
module generational_handle_allocator_core #(
    parameter int INDEX_BITS   = 10,
    parameter int VERSION_BITS = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_stall,
    input  logic [1:0]                          cmd,
    input  logic [INDEX_BITS+VERSION_BITS-1:0]  handle_in,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic [INDEX_BITS+VERSION_BITS-1:0]  handle_out,
    output logic                                is_live,
    output logic [1:0]                          status
);

    import ghal_pkg::*;

    localparam int HANDLE_BITS = INDEX_BITS + VERSION_BITS;
    localparam int TABLE_DEPTH = 2 ** INDEX_BITS;
    localparam logic [INDEX_BITS-1:0]   IDX_NULL   = {INDEX_BITS{1'b1}};
    localparam logic [INDEX_BITS-1:0]   IDX_ONE    = {{(INDEX_BITS-1){1'b0}}, 1'b1};
    localparam logic [VERSION_BITS-1:0] VER_ZERO   = {VERSION_BITS{1'b0}};
    localparam logic [VERSION_BITS-1:0] VER_ONE    = {{(VERSION_BITS-1){1'b0}}, 1'b1};
    localparam logic [HANDLE_BITS-1:0]  HANDLE_NULL = {HANDLE_BITS{1'b1}};

    alloc_state_t state_reg, state_next;

    logic [1:0]              cmd_reg, cmd_next;
    logic [HANDLE_BITS-1:0]  hin_reg, hin_next;
    logic [INDEX_BITS-1:0]   used_reg, used_next;
    logic [INDEX_BITS-1:0]   free_head_reg, free_head_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    logic [HANDLE_BITS-1:0]  handle_out_reg, handle_out_next;
    logic                    is_live_reg, is_live_next;
    logic [1:0]              status_reg, status_next;

    logic                    accept;
    logic                    ram_we;
    logic [INDEX_BITS-1:0]   ram_waddr;
    logic [HANDLE_BITS-1:0]  ram_wdata;
    logic [INDEX_BITS-1:0]   ram_raddr;
    logic [HANDLE_BITS-1:0]  ram_rdata;

    logic [INDEX_BITS-1:0]   hin_idx;
    logic [VERSION_BITS-1:0] hin_ver;
    logic                    slot_live;

    assign cmd_stall = (state_reg != ST_IDLE) || (rsp_valid_reg && rsp_stall);
    assign accept    = cmd_valid && !cmd_stall;

    // A create reads the free head, every other command reads the slot it names.
    assign ram_raddr = (cmd == CMD_CREATE) ? free_head_reg : handle_in[INDEX_BITS-1:0];

    ghal_ram #(
        .WIDTH (HANDLE_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign hin_idx   = hin_reg[INDEX_BITS-1:0];
    assign hin_ver   = hin_reg[HANDLE_BITS-1:INDEX_BITS];
    assign slot_live = (hin_idx < used_reg) && (ram_rdata == hin_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            free_head_reg <= IDX_NULL;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            free_head_reg <= free_head_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        hin_reg        <= hin_next;
        handle_out_reg <= handle_out_next;
        is_live_reg    <= is_live_next;
        status_reg     <= status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        hin_next        = hin_reg;
        used_next       = used_reg;
        free_head_next  = free_head_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        handle_out_next = handle_out_reg;
        is_live_next    = is_live_reg;
        status_next     = status_reg;
        ram_we          = 1'b0;
        ram_waddr       = hin_idx;
        ram_wdata       = hin_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = cmd;
                    hin_next   = handle_in;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next      = ST_IDLE;
                rsp_valid_next  = 1'b1;
                handle_out_next = hin_reg;
                is_live_next    = 1'b0;
                status_next     = STAT_OK;
                case (cmd_reg)
                    CMD_CREATE:
                    begin
                        if (free_head_reg != IDX_NULL)
                        begin
                            // Reuse the head slot with the version it kept when freed.
                            handle_out_next = {ram_rdata[HANDLE_BITS-1:INDEX_BITS],
                                               free_head_reg};
                            free_head_next  = ram_rdata[INDEX_BITS-1:0];
                            ram_we          = 1'b1;
                            ram_waddr       = free_head_reg;
                            ram_wdata       = {ram_rdata[HANDLE_BITS-1:INDEX_BITS],
                                               free_head_reg};
                            is_live_next    = 1'b1;
                        end
                        else if (used_reg != IDX_NULL)
                        begin
                            handle_out_next = {VER_ZERO, used_reg};
                            ram_we          = 1'b1;
                            ram_waddr       = used_reg;
                            ram_wdata       = {VER_ZERO, used_reg};
                            used_next       = used_reg + IDX_ONE;
                            is_live_next    = 1'b1;
                        end
                        else
                        begin
                            handle_out_next = HANDLE_NULL;
                            status_next     = STAT_FULL;
                        end
                    end
                    CMD_DESTROY:
                    begin
                        if (slot_live)
                        begin
                            // Bump the version and push the slot onto the free list.
                            ram_we         = 1'b1;
                            ram_waddr      = hin_idx;
                            ram_wdata      = {hin_ver + VER_ONE, free_head_reg};
                            free_head_next = hin_idx;
                            is_live_next   = 1'b1;
                        end
                        else
                        begin
                            status_next = STAT_STALE;
                        end
                    end
                    default:
                    begin
                        is_live_next = slot_live;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp_valid  = rsp_valid_reg;
    assign handle_out = handle_out_reg;
    assign is_live    = is_live_reg;
    assign status     = status_reg;

    // The free-list head, when set, is a slot that was handed out before.
    a_free_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (free_head_reg != IDX_NULL) |-> (free_head_reg < used_reg))
        else $error("free head points past the used slots");

    // The slot RAM is only written while an item is being executed.
    a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_EXEC))
        else $error("slot write outside execution");

    // A new result appears only right after an execution cycle.
    a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == ST_EXEC))
        else $error("result raised without execution");

    // A full report is only given when every slot but the reserved null index is in use.
    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (status_reg == STAT_FULL)) |->
            ((used_reg == IDX_NULL) && (free_head_reg == IDX_NULL) && !is_live_reg))
        else $error("table full reported with free slots");

endmodule
